@@ rtl/sbd_pkg.sv @@
// Shared constants and types for the signed binary to decimal digit converter.
package sbd_pkg;

  localparam int WIDTH  = 64;   // bits of the converted value, 2..64
  localparam int DIGITS = 20;   // decimal digits kept, 1..20
  localparam int DIG_W  = 4;
  localparam int CNT_W  = $clog2(WIDTH);
  localparam int IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  localparam logic [DIG_W-1:0] BCD_MAX = 4'd9;

  typedef logic [DIG_W-1:0] bcd_t;
  typedef bcd_t [DIGITS-1:0] bcd_vec_t;   // entry 0 least significant

  // Finished conversion handed from the converter to the digit emitter.
  typedef struct packed {
    logic     negative;
    bcd_vec_t digits;
  } conv_res_t;

  function automatic logic all_bcd(input bcd_vec_t v);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      if (v[i] > BCD_MAX) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

@@ rtl/sbd_dabble.sv @@
// Bit-serial shift-and-add-3 converter from a signed binary value to BCD digits.
module sbd_dabble (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [63:0]      in_value,
  output logic                    res_valid,
  input  logic                    res_stall,
  output sbd_pkg::conv_res_t      res
);
  import sbd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_DONE  = 3'b100
  } dab_state_t;

  dab_state_t       state_r, state_nxt;
  logic [WIDTH-1:0] mag_r;
  logic [WIDTH-1:0] val_in;
  logic [WIDTH-1:0] mag_in;
  logic [CNT_W-1:0] cnt_r;
  bcd_vec_t         digits_r;
  bcd_vec_t         shifted;
  bcd_vec_t         adj;
  logic [DIGITS:0]  carry;
  logic             neg_r;
  logic             accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign res_valid = (state_r == ST_DONE);
  assign res       = '{negative: neg_r, digits: digits_r};

  // Magnitude: two's-complement negate; the most negative value maps to 2^(WIDTH-1).
  assign val_in = in_value[WIDTH-1:0];
  assign mag_in = val_in[WIDTH-1] ? (~val_in + WIDTH'(1)) : val_in;

  // Add 3 to every digit of 5 or more, then shift the next magnitude bit in.
  always_comb begin
    carry[0] = mag_r[WIDTH-1];
    for (int d = 0; d < DIGITS; d++) begin
      adj[d]       = (digits_r[d] >= 4'd5) ? (digits_r[d] + 4'd3) : digits_r[d];
      shifted[d]   = {adj[d][DIG_W-2:0], carry[d]};
      carry[d+1]   = adj[d][DIG_W-1];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (cnt_r == CNT_W'(WIDTH - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r    <= mag_in;
      neg_r    <= val_in[WIDTH-1];
      digits_r <= '0;
      cnt_r    <= '0;
    end else if (state_r == ST_SHIFT) begin
      mag_r    <= {mag_r[WIDTH-2:0], 1'b0};
      digits_r <= shifted;
      cnt_r    <= cnt_r + CNT_W'(1);
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("converter state not one-hot");

  // The bit counter has stepped once per shifted bit, wrapping at its width.
  a_done_after_all_bits: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (cnt_r == CNT_W'(WIDTH)))
    else $error("result offered before all bits were shifted");

  a_digits_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> all_bcd(digits_r))
    else $error("converter produced a non-decimal digit");

endmodule

@@ rtl/sbd_emit.sv @@
// Digit emitter: drops leading zeros and shifts digits out most significant first.
module sbd_emit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    res_valid,
  output logic                    res_stall,
  input  sbd_pkg::conv_res_t      res,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [3:0]              out_digit,
  output logic                    out_negative,
  output logic                    out_last
);
  import sbd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SKIP = 3'b010,
    ST_EMIT = 3'b100
  } emit_state_t;

  emit_state_t      state_r, state_nxt;
  bcd_vec_t         digits_r;
  logic [IDX_W-1:0] pos_r;      // index of the digit now at the top
  logic             neg_r;
  logic             load;
  logic             advance;
  logic             top_zero;

  assign res_stall    = (state_r != ST_IDLE);
  assign load         = res_valid && !res_stall;
  assign top_zero     = (digits_r[DIGITS-1] == '0);
  assign out_valid    = (state_r == ST_EMIT);
  assign out_digit    = digits_r[DIGITS-1];
  assign out_negative = neg_r;
  assign out_last     = (pos_r == '0);
  // A zero value keeps its last digit, so skipping stops at position 0.
  assign advance      = ((state_r == ST_SKIP) && top_zero && (pos_r != '0)) ||
                        ((state_r == ST_EMIT) && !out_stall && (pos_r != '0));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (load) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!top_zero || (pos_r == '0)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_stall && (pos_r == '0)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digits_r <= res.digits;
      neg_r    <= res.negative;
      pos_r    <= IDX_W'(DIGITS - 1);
    end else if (advance) begin
      digits_r <= bcd_vec_t'(digits_r << DIG_W);
      pos_r    <= pos_r - IDX_W'(1);
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("emitter state not one-hot");

  a_no_leading_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ((out_digit != '0) || out_last))
    else $error("leading zero emitted");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit <= BCD_MAX))
    else $error("emitted digit above 9");

endmodule

@@ rtl/signed_binary_to_decimal_digits.sv @@
// Top level of the signed binary to decimal digit converter.
//
// Input channel in_valid / in_stall / in_value carries one signed 64-bit value
// per item. Result channel out_valid / out_stall delivers the decimal digits of
// its magnitude, most significant first, one item per digit, leading zeros
// dropped; out_negative gives the sign and out_last marks the final digit.
// Zero gives the single digit 0.
// The converter loads the item, shifts one magnitude bit per cycle through all
// digits and then hands the result off. The emitter then drops leading zeros
// and sends the remaining digits. Converter and emitter overlap: the converter
// can take a new item while the emitter sends the last one, but not before it
// has handed off its own current item.
// A stalled receiver holds the current digit; the converter finishes the next
// item and waits, and in_stall stays high until it can hand it over.
// Synchronous reset (rst_n low) empties both stages; no item is in flight.
module signed_binary_to_decimal_digits (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [63:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_digit,
  output logic               out_negative,
  output logic               out_last
);
  import sbd_pkg::*;

  conv_res_t conv;
  logic      conv_valid;
  logic      conv_stall;

  sbd_dabble u_dabble (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .res_valid (conv_valid),
    .res_stall (conv_stall),
    .res       (conv)
  );

  sbd_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (conv_valid),
    .res_stall    (conv_stall),
    .res          (conv),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_digit    (out_digit),
    .out_negative (out_negative),
    .out_last     (out_last)
  );

endmodule

@@ dv/tb.sv @@
// Self-checking testbench: random and corner values in, decimal digit items checked out.
`timescale 1ns / 1ps

module tb;
  import sbd_pkg::*;

  localparam int LIMIT_CYCLES = 800000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    bcd_t digit;
    logic negative;
    logic last;
  } digit_item_t;

  // Predicts the digit items of each accepted value and checks them in order.
  class digit_scoreboard;
    digit_item_t pending_digits[$];
    int errors;
    int seen;

    function new();
      errors = 0;
      seen = 0;
    endfunction

    task report(input string msg);
      $display("ERROR result %0d: %s", seen, msg);
      errors++;
    endtask

    function int pending();
      return pending_digits.size();
    endfunction

    function void note_value(input logic [63:0] raw);
      logic [63:0] mask;
      logic [63:0] v;
      logic [63:0] mag;
      logic neg;
      bcd_t dig[DIGITS];
      int top;
      digit_item_t item;
      mask = (WIDTH == 64) ? '1 : ((64'd1 << WIDTH) - 64'd1);
      v = raw & mask;
      neg = v[WIDTH-1];
      mag = neg ? ((~v + 64'd1) & mask) : v;
      // digits beyond DIGITS are dropped, leaving the magnitude mod 10^DIGITS
      for (int i = 0; i < DIGITS; i++) begin
        dig[i] = bcd_t'(mag % 64'd10);
        mag = mag / 64'd10;
      end
      top = 0;
      for (int i = DIGITS - 1; i >= 0; i--) begin
        if (dig[i] != '0 && top == 0) begin
          top = i;
        end
      end
      for (int i = top; i >= 0; i--) begin
        item.digit = dig[i];
        item.negative = neg;
        item.last = (i == 0);
        pending_digits.push_back(item);
      end
    endfunction

    task check_digit(input bcd_t digit, input logic negative, input logic last);
      digit_item_t want;
      if (pending_digits.size() == 0) begin
        report($sformatf("unexpected item digit=%0d neg=%0b last=%0b",
                         digit, negative, last));
      end else begin
        want = pending_digits.pop_front();
        if (digit !== want.digit)
          report($sformatf("digit %0d, expected %0d", digit, want.digit));
        if (negative !== want.negative)
          report($sformatf("negative %0b, expected %0b", negative, want.negative));
        if (last !== want.last)
          report($sformatf("last %0b, expected %0b", last, want.last));
      end
      seen++;
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [63:0] in_value;
  logic               out_valid;
  logic               out_stall;
  logic [3:0]         out_digit;
  logic               out_negative;
  logic               out_last;

  int in_gap_pct;
  int out_stall_pct;
  int cycles;
  digit_scoreboard sb = new();

  signed_binary_to_decimal_digits uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_digit    (out_digit),
    .out_negative (out_negative),
    .out_last     (out_last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_value(in_value);
    end
    if (rst_n && out_valid && !out_stall) begin
      sb.check_digit(out_digit, out_negative, out_last);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d items outstanding", cycles, sb.pending());
      $display("signed_binary_to_decimal_digits regression: fail");
      $finish;
    end
  end

  // Keeps valid high across back-to-back items; drops it only for a gap.
  task automatic send_value(input logic [63:0] v);
    if ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < in_gap_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_value();
    int kind;
    int k;
    logic [63:0] m;
    logic [63:0] p;
    kind = $urandom_range(9);
    m = {$urandom, $urandom};
    p = 64'd1;
    k = $urandom_range(19, 1);
    for (int i = 0; i < k; i++) p = p * 64'd10;
    if (kind < 4) begin
      return m;
    end else if (kind < 8) begin
      // random digit count, random sign
      m = m % p;
      return $urandom_range(1) ? -m : m;
    end else if (kind == 8) begin
      // around a power of ten
      m = (k < 19) ? p + 64'd2 - 64'($urandom_range(4)) : p - 64'($urandom_range(3));
      return $urandom_range(1) ? -m : m;
    end else begin
      // near the ends of the range
      m = 64'($urandom_range(20));
      return $urandom_range(1) ? (64'h7FFF_FFFF_FFFF_FFFF - m)
                               : (64'h8000_0000_0000_0000 + m);
    end
  endfunction

  logic [63:0] corner_values[20];

  initial begin
    cycles = 0;
    in_gap_pct = 9;
    out_stall_pct = 54;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_value <= '0;
    corner_values = '{
      64'sd0, 64'sd1, -64'sd1, 64'sd9, -64'sd9, 64'sd10, -64'sd10, 64'sd99, 64'sd100,
      64'sd12345, -64'sd67890, 64'sd999999999999999999, 64'sd1000000000000000000,
      -64'sd1000000000000000000, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
      64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
      64'sd1234567890123456789
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_values[i]) send_value(corner_values[i]);
    repeat (150) send_value(pick_value());

    in_gap_pct = 54;
    out_stall_pct = 9;
    repeat (150) send_value(pick_value());

    in_gap_pct = 0;
    out_stall_pct = 0;
    repeat (140) send_value(pick_value());
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("signed_binary_to_decimal_digits regression: pass");
    end else begin
      $display("signed_binary_to_decimal_digits regression: fail");
    end
    $finish;
  end

endmodule
